// File: rtl/core/oal_pkg.sv
// Shared widths, operation and status codes, and controller/datapath interface types.
package oal_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int FUNC_W  = 3;
  localparam int POS_W   = 5;
  localparam int VAL_W   = 32;
  localparam int CFG_W   = 5;
  localparam int STAT_W  = 3;
  localparam int FOUND_W = 4;
  localparam int COUNT_W = 5;

  localparam int S_DATA_W = ((POS_W + VAL_W + 7) / 8) * 8;
  localparam int M_FIELD_W = STAT_W + FOUND_W + COUNT_W + 2;
  localparam int M_DATA_W = ((M_FIELD_W + 7) / 8) * 8;

  localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT = 3'd0,
    FN_DELETE = 3'd1,
    FN_LOCATE = 3'd2,
    FN_CHANGE = 3'd3,
    FN_CLEAR  = 3'd4
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_COUNT,
    IDX_POS,
    IDX_ZERO,
    IDX_INC,
    IDX_DEC
  } idx_op_t;

  typedef enum logic [1:0] {
    RD_IDX,
    RD_IDX_M1,
    RD_IDX_P1
  } rd_sel_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_CLR
  } cnt_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_item;
    idx_op_t idx_op;
    rd_sel_t rd_sel;
    logic    wr_en;
    logic    wr_rdata;
    logic    wr_at_pos;
    cnt_op_t cnt_op;
    logic    save_found;
    logic    load_result;
    status_t res_status;
  } oal_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              full;
    logic              empty;
    logic              pos_gt;
    logic              pos_ge;
    logic              idx_eq_pos;
    logic              idx_last;
    logic              idx_ge_count;
    logic              match;
  } oal_sts_t;

endpackage

// File: rtl/core/oal_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module oal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/oal_dpath.sv
// Datapath: item registers, entry RAM, index counter, count, capacity and result register.
module oal_dpath import oal_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic [FUNC_W-1:0]  item_func,
  input  logic [POS_W-1:0]   item_pos,
  input  logic [VAL_W-1:0]   item_val,
  input  oal_cmd_t           cmd,
  output oal_sts_t           sts,
  output logic [STAT_W-1:0]  res_status,
  output logic [FOUND_W-1:0] res_found,
  output logic [COUNT_W-1:0] res_count,
  output logic               res_empty,
  output logic               res_full
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CMP_A = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int CMP_W = (CMP_A > CFG_W) ? CMP_A : CFG_W;

  logic [FUNC_W-1:0]  func_q;
  logic [POS_W-1:0]   pos_q;
  logic [VAL_W-1:0]   val_q;
  logic [CNT_W-1:0]   idx;
  logic [CNT_W-1:0]   idx_next;
  logic [CNT_W-1:0]   entry_count;
  logic [CNT_W-1:0]   entry_count_next;
  logic [CFG_W-1:0]   cap_q;
  logic [FOUND_W-1:0] found_q;

  logic [CNT_W-1:0] idx_m1;
  logic [CNT_W-1:0] idx_p1;
  logic [CNT_W-1:0] rd_idx;
  logic [IDX_W-1:0] raddr;
  logic [IDX_W-1:0] waddr;
  logic [VAL_W-1:0] wdata;
  logic [VAL_W-1:0] rdata;

  logic [CMP_W-1:0] pos_cmp;
  logic [CMP_W-1:0] cnt_cmp;
  logic [CMP_W-1:0] idx_cmp;
  logic [CMP_W-1:0] cap_cmp;
  logic [CMP_W-1:0] cap_lim;
  logic [CMP_W-1:0] cap_use;

  assign pos_cmp = CMP_W'(pos_q);
  assign cnt_cmp = CMP_W'(entry_count);
  assign idx_cmp = CMP_W'(idx);
  assign cap_cmp = CMP_W'(cap_q);
  assign cap_lim = CMP_W'(CAPACITY);

  // A capacity of zero acts as one; one above the storage acts as the storage size.
  always_comb begin
    if (cap_q == '0) begin
      cap_use = CMP_W'(1);
    end else if (cap_cmp > cap_lim) begin
      cap_use = cap_lim;
    end else begin
      cap_use = cap_cmp;
    end
  end

  assign idx_m1 = idx - CNT_W'(1);
  assign idx_p1 = idx + CNT_W'(1);

  always_comb begin
    case (cmd.rd_sel)
      RD_IDX_M1: rd_idx = idx_m1;
      RD_IDX_P1: rd_idx = idx_p1;
      default:   rd_idx = idx;
    endcase
  end

  assign raddr = rd_idx[IDX_W-1:0];
  assign waddr = cmd.wr_at_pos ? pos_cmp[IDX_W-1:0] : idx[IDX_W-1:0];
  assign wdata = cmd.wr_rdata ? rdata : val_q;

  oal_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    sts.func         = func_q;
    sts.full         = cnt_cmp >= cap_use;
    sts.empty        = entry_count == '0;
    sts.pos_gt       = pos_cmp > cnt_cmp;
    sts.pos_ge       = pos_cmp >= cnt_cmp;
    sts.idx_eq_pos   = idx_cmp == pos_cmp;
    sts.idx_last     = (idx_cmp + CMP_W'(1)) >= cnt_cmp;
    sts.idx_ge_count = idx_cmp >= cnt_cmp;
    sts.match        = rdata == val_q;
  end

  always_comb begin
    case (cmd.idx_op)
      IDX_COUNT: idx_next = entry_count;
      IDX_POS:   idx_next = CNT_W'(pos_q);
      IDX_ZERO:  idx_next = '0;
      IDX_INC:   idx_next = idx_p1;
      IDX_DEC:   idx_next = idx_m1;
      default:   idx_next = idx;
    endcase
  end

  always_comb begin
    case (cmd.cnt_op)
      CNT_INC: entry_count_next = entry_count + CNT_W'(1);
      CNT_DEC: entry_count_next = entry_count - CNT_W'(1);
      CNT_CLR: entry_count_next = '0;
      default: entry_count_next = entry_count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      cap_q       <= CAP_RESET;
    end else begin
      entry_count <= entry_count_next;
      if (cfg_we) begin
        cap_q <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (cmd.load_item) begin
      func_q  <= item_func;
      pos_q   <= item_pos;
      val_q   <= item_val;
      found_q <= '0;
    end else if (cmd.save_found) begin
      found_q <= FOUND_W'(idx);
    end
    if (cmd.load_result) begin
      res_status <= cmd.res_status;
      res_found  <= found_q;
      res_count  <= COUNT_W'(entry_count);
      res_empty  <= sts.empty;
      res_full   <= sts.full;
    end
  end

endmodule

// File: rtl/core/oal_ctrl.sv
// Controller: sequences each operation and owns the input and output handshakes.
module oal_ctrl import oal_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  output logic     m_tvalid,
  input  logic     m_tready,
  input  oal_sts_t sts,
  output oal_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_UP_TEST,
    S_UP_MOVE,
    S_DN_TEST,
    S_DN_MOVE,
    S_SR_TEST,
    S_SR_CMP,
    S_DONE
  } state_t;

  state_t  state;
  state_t  state_next;
  status_t status_q;
  status_t status_next;

  assign s_tready = state == S_IDLE;

  always_comb begin
    state_next      = state;
    status_next     = status_q;
    cmd.load_item   = 1'b0;
    cmd.idx_op      = IDX_HOLD;
    cmd.rd_sel      = RD_IDX;
    cmd.wr_en       = 1'b0;
    cmd.wr_rdata    = 1'b0;
    cmd.wr_at_pos   = 1'b0;
    cmd.cnt_op      = CNT_HOLD;
    cmd.save_found  = 1'b0;
    cmd.load_result = 1'b0;
    cmd.res_status  = status_q;

    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load_item = 1'b1;
          state_next    = S_CHECK;
        end
      end

      S_CHECK: begin
        status_next = ST_OK;
        state_next  = S_DONE;
        case (sts.func)
          FN_INSERT: begin
            if (sts.full) begin
              status_next = ST_FULL;
            end else if (sts.pos_gt) begin
              status_next = ST_BADPOS;
            end else begin
              cmd.idx_op = IDX_COUNT;
              state_next = S_UP_TEST;
            end
          end
          FN_DELETE: begin
            if (sts.empty) begin
              status_next = ST_EMPTY;
            end else if (sts.pos_ge) begin
              status_next = ST_BADPOS;
            end else begin
              cmd.idx_op = IDX_POS;
              state_next = S_DN_TEST;
            end
          end
          FN_LOCATE: begin
            status_next = ST_NOTFOUND;
            cmd.idx_op  = IDX_ZERO;
            state_next  = S_SR_TEST;
          end
          FN_CHANGE: begin
            if (sts.empty) begin
              status_next = ST_EMPTY;
            end else if (sts.pos_ge) begin
              status_next = ST_BADPOS;
            end else begin
              cmd.wr_en     = 1'b1;
              cmd.wr_at_pos = 1'b1;
            end
          end
          FN_CLEAR: begin
            cmd.cnt_op = CNT_CLR;
          end
          default: begin
          end
        endcase
      end

      // Insert walks from the old end down to the target, moving one entry up per pass.
      S_UP_TEST: begin
        if (sts.idx_eq_pos) begin
          cmd.wr_en  = 1'b1;
          cmd.cnt_op = CNT_INC;
          state_next = S_DONE;
        end else begin
          cmd.rd_sel = RD_IDX_M1;
          state_next = S_UP_MOVE;
        end
      end

      S_UP_MOVE: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_rdata = 1'b1;
        cmd.idx_op   = IDX_DEC;
        state_next   = S_UP_TEST;
      end

      // Delete walks from the target up, moving one entry down per pass.
      S_DN_TEST: begin
        if (sts.idx_last) begin
          cmd.cnt_op = CNT_DEC;
          state_next = S_DONE;
        end else begin
          cmd.rd_sel = RD_IDX_P1;
          state_next = S_DN_MOVE;
        end
      end

      S_DN_MOVE: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_rdata = 1'b1;
        cmd.idx_op   = IDX_INC;
        state_next   = S_DN_TEST;
      end

      S_SR_TEST: begin
        if (sts.idx_ge_count) begin
          state_next = S_DONE;
        end else begin
          cmd.rd_sel = RD_IDX;
          state_next = S_SR_CMP;
        end
      end

      S_SR_CMP: begin
        if (sts.match) begin
          status_next    = ST_OK;
          cmd.save_found = 1'b1;
          state_next     = S_DONE;
        end else begin
          cmd.idx_op = IDX_INC;
          state_next = S_SR_TEST;
        end
      end

      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          cmd.load_result = 1'b1;
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      status_q <= ST_OK;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      status_q <= status_next;
      if (cmd.load_result) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/core/ordered_array_list_top.sv
// Top level of the ordered array list: handshake ports, controller and datapath.
//
// The block keeps an ordered list of signed 32-bit values and a count. Each transfer
// on the slave stream carries one operation in s_tuser (insert, delete, locate,
// change or clear) with a position and a value in s_tdata, and produces exactly one
// transfer on the master stream with the status, the first matching position of a
// locate, the count after the operation and the empty and full flags.
// The capacity register is written through the cfg channel, which is always ready;
// write it only while no operation is in flight.
// One operation is worked on at a time. Insert and delete move one entry per pass,
// and locate compares one entry per pass, as each pass goes through the one
// registered read port of the entry RAM. Change, clear, unknown and rejected
// operations go straight from the check to the result, and the slave side is ready
// again in the cycle right after the result is loaded.
// The result sits in an output register, so a new item is taken while a result still
// waits; if the receiver stalls, that next item finishes its work and then holds
// until the output register frees up.
// Reset clears the count, restores the capacity register to 16 and drops m_tvalid;
// the entry RAM is not cleared, as no entry is read before it was written.
module ordered_array_list_top import oal_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // Slave stream.
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // position[4:0], value[36:5], zero pad above
  input  logic [FUNC_W-1:0]   s_tuser,   // func[2:0]
  // Master stream.
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,   // status[2:0], found_position[6:3],
                                         // count[11:7], is_empty[12], is_full[13], zero pad
  // Capacity register write channel.
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_W-1:0]    cfg_data   // capacity[4:0]
);

  oal_cmd_t           cmd;
  oal_sts_t           sts;
  logic [STAT_W-1:0]  res_status;
  logic [FOUND_W-1:0] res_found;
  logic [COUNT_W-1:0] res_count;
  logic               res_empty;
  logic               res_full;

  assign cfg_ready = 1'b1;

  oal_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  oal_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid & cfg_ready),
    .cfg_data   (cfg_data),
    .item_func  (s_tuser),
    .item_pos   (s_tdata[POS_W-1:0]),
    .item_val   (s_tdata[POS_W+VAL_W-1:POS_W]),
    .cmd        (cmd),
    .sts        (sts),
    .res_status (res_status),
    .res_found  (res_found),
    .res_count  (res_count),
    .res_empty  (res_empty),
    .res_full   (res_full)
  );

  // The pad bits above the result fields are driven as zeros.
  assign m_tdata = M_DATA_W'({res_full, res_empty, res_count, res_found, res_status});

endmodule

// File: rtl/core/oal_checker.sv
// Port-level checker for the ordered array list, bound to the top level.
module oal_checker import oal_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata
);

  // Reset leaves no result pending.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // A stalled result keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed or dropped");

  // Only one operation is in flight: the slave side closes after every transfer.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item taken while one is in flight");

  // When the empty flag is set, the count is always zero.
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[12] |-> m_tdata[11:7] == '0)
    else $error("empty flag with nonzero count");

  // A nonzero found position only comes with a successful locate.
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[6:3] != '0 |-> m_tdata[2:0] == ST_OK)
    else $error("found position reported with an error status");

endmodule

bind ordered_array_list_top oal_checker u_oal_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// File: test/ordered_array_list_top_tb.sv
// Self-checking testbench for the ordered array list: directed table, random phases, scoreboard.
module ordered_array_list_top_tb import oal_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // An operation keeps the block busy longer the more entries it moves or compares,
  // so a full list is the slowest case. This pad covers that.
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned LIMIT_CYCLES  = 1_000_000;
  localparam int unsigned PHASES        = 8;
  localparam int unsigned PHASE_OPS     = 225;
  localparam int unsigned PRINT_LIMIT   = 40;
  localparam int unsigned HOLD_CYCLES   = 300;

  // Function code outside the defined set; the block must treat it as a no-op.
  localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [POS_W-1:0]  pos;
    logic [VAL_W-1:0]  value;
  } list_op_t;

  typedef struct packed {
    status_t            status;
    logic [FOUND_W-1:0] found;
    logic [COUNT_W-1:0] count;
    logic               empty;
    logic               full;
  } list_result_t;

  // One row of the directed table: either a capacity write or an operation,
  // the latter optionally with its expected result spelled out by hand.
  typedef struct packed {
    bit               is_cap;
    logic [CFG_W-1:0] cap;
    list_op_t         op;
    bit               typed;
    list_result_t     want;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic [FUNC_W-1:0]   s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFG_W-1:0]    cfg_data = '0;

  // Shadow copy of the list contents, length and capacity register.
  logic [VAL_W-1:0] shadow_vals [CAPACITY_DEF];
  int unsigned      shadow_len = 0;
  logic [CFG_W-1:0] shadow_cap = CAP_RESET;

  list_result_t pending_results [$];
  dir_row_t     dir_rows [$];
  int unsigned  mismatch_count = 0;
  int unsigned  results_seen = 0;
  int unsigned  cycle_count = 0;

  // Stimulus controls shared between the sequence and the receiver.
  bit          filling = 1'b1;
  bit          tx_quiet = 1'b0;
  bit          rx_quiet = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned hold_len = 0;

  logic [VAL_W-1:0] value_pool [6] = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                                       32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555};

  ordered_array_list_top #(.CAPACITY(CAPACITY_DEF)) DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Capacity actually in force: zero behaves as one, anything past the array size
  // behaves as the array size.
  function automatic int unsigned eff_cap();
    if (shadow_cap == 0) return 1;
    if (shadow_cap > CAPACITY_DEF) return CAPACITY_DEF;
    return shadow_cap;
  endfunction

  // Applies one operation to the shadow list and returns the result it produces.
  function automatic list_result_t list_apply(input list_op_t op);
    list_result_t r;
    int unsigned  i;
    int unsigned  lim;
    lim = eff_cap();
    r.status = ST_OK;
    r.found = '0;
    case (op.func)
      FN_INSERT: begin
        // Full is checked ahead of the position.
        if (shadow_len >= lim) begin
          r.status = ST_FULL;
        end else if (op.pos > shadow_len) begin
          r.status = ST_BADPOS;
        end else begin
          for (i = shadow_len; i > op.pos; i--) shadow_vals[i] = shadow_vals[i-1];
          shadow_vals[op.pos] = op.value;
          shadow_len++;
        end
      end
      FN_DELETE: begin
        if (shadow_len == 0) begin
          r.status = ST_EMPTY;
        end else if (op.pos >= shadow_len) begin
          r.status = ST_BADPOS;
        end else begin
          for (i = op.pos + 1; i < shadow_len; i++) shadow_vals[i-1] = shadow_vals[i];
          shadow_len--;
        end
      end
      FN_LOCATE: begin
        r.status = ST_NOTFOUND;
        for (i = 0; i < shadow_len; i++) begin
          if (shadow_vals[i] == op.value) begin
            r.status = ST_OK;
            r.found = FOUND_W'(i);
            break;
          end
        end
      end
      FN_CHANGE: begin
        if (shadow_len == 0) begin
          r.status = ST_EMPTY;
        end else if (op.pos >= shadow_len) begin
          r.status = ST_BADPOS;
        end else begin
          shadow_vals[op.pos] = op.value;
        end
      end
      FN_CLEAR: begin
        shadow_len = 0;
      end
      default: begin
      end
    endcase
    r.count = COUNT_W'(shadow_len);
    r.empty = (shadow_len == 0);
    r.full = (shadow_len >= lim);
    return r;
  endfunction

  // Random operation shaped by the list state: runs of mostly inserts fill the
  // list up to full, runs of mostly deletes drain it back to empty.
  function automatic list_op_t draw_op();
    list_op_t    op;
    int unsigned r;
    if (shadow_len >= eff_cap()) filling = 1'b0;
    else if (shadow_len == 0) filling = 1'b1;
    else if ($urandom_range(0, 29) == 0) filling = !filling;
    r = $urandom_range(0, 99);
    if (filling) begin
      op.func = r < 55 ? FN_INSERT : r < 67 ? FN_DELETE : r < 82 ? FN_LOCATE :
                r < 98 ? FN_CHANGE : FN_CLEAR;
    end else begin
      op.func = r < 15 ? FN_INSERT : r < 60 ? FN_DELETE : r < 80 ? FN_LOCATE :
                r < 98 ? FN_CHANGE : FN_CLEAR;
    end
    if ($urandom_range(0, 99) < 15) op.pos = POS_W'($urandom_range(0, CAPACITY_DEF));
    else if (op.func == FN_INSERT) op.pos = POS_W'($urandom_range(0, shadow_len));
    else if (shadow_len > 0) op.pos = POS_W'($urandom_range(0, shadow_len - 1));
    else op.pos = '0;
    // Locates mostly look for a value that is present; the small pool of values
    // makes duplicates common, so the first-match rule gets exercised.
    if (op.func == FN_LOCATE && shadow_len > 0 && $urandom_range(0, 99) < 60)
      op.value = shadow_vals[$urandom_range(0, shadow_len - 1)];
    else if ($urandom_range(0, 99) < 40) op.value = value_pool[$urandom_range(0, 5)];
    else op.value = $urandom;
    return op;
  endfunction

  function automatic void dir_cap(input logic [CFG_W-1:0] cap);
    dir_row_t row;
    row = '0;
    row.is_cap = 1'b1;
    row.cap = cap;
    dir_rows.push_back(row);
  endfunction

  function automatic void dir_op(input logic [FUNC_W-1:0] func, input logic [POS_W-1:0] pos,
                                 input logic [VAL_W-1:0] value);
    dir_row_t row;
    row = '0;
    row.op = '{func, pos, value};
    dir_rows.push_back(row);
  endfunction

  function automatic void dir_chk(input logic [FUNC_W-1:0] func, input logic [POS_W-1:0] pos,
                                  input logic [VAL_W-1:0] value, input status_t st,
                                  input int unsigned found, input int unsigned cnt,
                                  input bit emp, input bit ful);
    dir_row_t row;
    row = '0;
    row.op = '{func, pos, value};
    row.typed = 1'b1;
    row.want = '{st, FOUND_W'(found), COUNT_W'(cnt), emp, ful};
    dir_rows.push_back(row);
  endfunction

  task automatic flag_mismatch(input string what);
    if (mismatch_count < PRINT_LIMIT)
      $display("ERROR @%0t result %0d: %s", $time, results_seen, what);
    mismatch_count++;
  endtask

  // Offers one operation and waits for its transfer. The expected result is
  // queued at the accepting edge; a hand-typed expectation takes precedence, but
  // the shadow list is still updated.
  task automatic offer(input list_op_t op, input bit typed, input list_result_t typed_want);
    list_result_t predicted;
    s_tvalid <= 1'b1;
    s_tdata <= S_DATA_W'({op.value, op.pos});
    s_tuser <= op.func;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = list_apply(op);
    pending_results.push_back(typed ? typed_want : predicted);
  endtask

  // Mostly back-to-back, sometimes a short gap, now and then a long one.
  task automatic sender_gap();
    int unsigned r;
    int unsigned gap;
    r = $urandom_range(0, 99);
    if (tx_quiet || r < 60) gap = 0;
    else if (r < 95) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The capacity register is only written while the block holds no work.
  task automatic set_capacity(input logic [CFG_W-1:0] cap);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    shadow_cap = cap;
  endtask

  // Directed table. Rows with a typed expectation are simple enough to read off
  // by eye; the others go through the shadow list.
  function automatic void build_table();
    // Empty list: every operation that needs an entry is rejected.
    dir_chk(FN_LOCATE, 5'd0,  32'h0000_0000, ST_NOTFOUND, 0, 0, 1, 0);
    dir_chk(FN_DELETE, 5'd0,  32'h0000_0000, ST_EMPTY,    0, 0, 1, 0);
    dir_chk(FN_CHANGE, 5'd0,  32'h0000_0001, ST_EMPTY,    0, 0, 1, 0);
    dir_chk(FN_INSERT, 5'd1,  32'h0000_0001, ST_BADPOS,   0, 0, 1, 0);
    // Extreme values at the front, the back and the front again.
    dir_chk(FN_INSERT, 5'd0,  32'h8000_0000, ST_OK,       0, 1, 0, 0);
    dir_chk(FN_INSERT, 5'd1,  32'h7FFF_FFFF, ST_OK,       0, 2, 0, 0);
    dir_chk(FN_INSERT, 5'd0,  32'hFFFF_FFFF, ST_OK,       0, 3, 0, 0);
    dir_chk(FN_LOCATE, 5'd0,  32'h7FFF_FFFF, ST_OK,       2, 3, 0, 0);
    dir_chk(FN_LOCATE, 5'd0,  32'h0000_0000, ST_NOTFOUND, 0, 3, 0, 0);
    dir_chk(FN_CHANGE, 5'd2,  32'h0000_0000, ST_OK,       0, 3, 0, 0);
    // Positions past the end, including position 16.
    dir_chk(FN_CHANGE, 5'd3,  32'h0000_0005, ST_BADPOS,   0, 3, 0, 0);
    dir_chk(FN_DELETE, 5'd3,  32'h0000_0000, ST_BADPOS,   0, 3, 0, 0);
    dir_chk(FN_DELETE, 5'd16, 32'hAAAA_5555, ST_BADPOS,   0, 3, 0, 0);
    dir_chk(FN_INSERT, 5'd16, 32'h0000_0000, ST_BADPOS,   0, 3, 0, 0);
    // An undefined function code leaves everything alone.
    dir_chk(FN_UNUSED, 5'd0,  32'h0000_0000, ST_OK,       0, 3, 0, 0);
    dir_chk(FN_DELETE, 5'd0,  32'h0000_0000, ST_OK,       0, 2, 0, 0);
    dir_op(FN_INSERT, 5'd2, 32'h5555_5555);
    dir_op(FN_INSERT, 5'd1, 32'h1234_5678);
    dir_op(FN_DELETE, 5'd1, 32'h0000_0000);
    dir_op(FN_LOCATE, 5'd0, 32'h5555_5555);
    dir_chk(FN_CLEAR,  5'd0,  32'h0000_0000, ST_OK,       0, 0, 1, 0);
    // Small capacity: reach full, then lower the capacity below the count.
    dir_cap(5'd2);
    dir_chk(FN_INSERT, 5'd0,  32'h0000_0005, ST_OK,       0, 1, 0, 0);
    dir_chk(FN_INSERT, 5'd0,  32'h0000_0006, ST_OK,       0, 2, 0, 1);
    dir_chk(FN_INSERT, 5'd0,  32'h0000_0007, ST_FULL,     0, 2, 0, 1);
    dir_cap(5'd1);
    dir_chk(FN_LOCATE, 5'd0,  32'h0000_0005, ST_OK,       1, 2, 0, 1);
    // Full wins over a bad position.
    dir_chk(FN_INSERT, 5'd9,  32'h0000_0000, ST_FULL,     0, 2, 0, 1);
    // A capacity of zero acts as one, and one above the array size as the size.
    dir_cap(5'd0);
    dir_chk(FN_INSERT, 5'd1,  32'h0000_0001, ST_FULL,     0, 2, 0, 1);
    dir_chk(FN_DELETE, 5'd1,  32'h0000_0000, ST_OK,       0, 1, 0, 1);
    dir_cap(5'd31);
    dir_chk(FN_INSERT, 5'd1,  32'hDEAD_BEEF, ST_OK,       0, 2, 0, 0);
  endfunction

  // Receiver: random stalls, a quiet mode that never stalls, and one long
  // hold-off on request that lets the block back up into its input.
  initial begin
    int unsigned stall_left;
    int unsigned r;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        m_tready <= 1'b1;
      end else if (rx_quiet) begin
        m_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          m_tready <= 1'b1;
        end else begin
          stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(9, 39);
          m_tready <= 1'b0;
        end
      end
    end
  end

  // Scoreboard: each result transfer is compared field by field against the
  // oldest expectation. Values are read before this edge's updates land.
  always @(posedge clk) begin : result_check
    list_result_t got;
    list_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.status = status_t'(m_tdata[2:0]);
      got.found = m_tdata[6:3];
      got.count = m_tdata[11:7];
      got.empty = m_tdata[12];
      got.full = m_tdata[13];
      if (pending_results.size() == 0) begin
        flag_mismatch("result transfer with no operation outstanding");
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status)
          flag_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.found !== want.found)
          flag_mismatch($sformatf("found_position %0d, expected %0d", got.found, want.found));
        if (got.count !== want.count)
          flag_mismatch($sformatf("count %0d, expected %0d", got.count, want.count));
        if (got.empty !== want.empty)
          flag_mismatch($sformatf("is_empty %0b, expected %0b", got.empty, want.empty));
        if (got.full !== want.full)
          flag_mismatch($sformatf("is_full %0b, expected %0b", got.full, want.full));
      end
      results_seen++;
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("ordered_array_list_top_tb failed");
      $finish;
    end
  end

  // Main sequence: reset, directed table, then random phases at several
  // capacities, then wait for the last results and print the verdict.
  initial begin
    logic [CFG_W-1:0] phase_cap [PHASES];
    int unsigned      ph;
    int unsigned      n;
    phase_cap = '{5'd16, 5'd3, 5'd1, 5'd16, 5'd0, 5'd31, 5'd8, 5'd12};
    phase_cap[PHASES-1] = CFG_W'($urandom_range(1, CAPACITY_DEF));
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    build_table();
    foreach (dir_rows[k]) begin
      if (dir_rows[k].is_cap) begin
        set_capacity(dir_rows[k].cap);
      end else begin
        offer(dir_rows[k].op, dir_rows[k].typed, dir_rows[k].want);
        sender_gap();
      end
    end

    for (ph = 0; ph < PHASES; ph++) begin
      set_capacity(phase_cap[ph]);
      // One phase runs with no idling on either side at all.
      tx_quiet = (ph == 4);
      rx_quiet = (ph == 4);
      // At the start of the second full-size phase the receiver stops for a long
      // while; the sender keeps offering so the block stalls its input.
      if (ph == 3) begin
        hold_len = HOLD_CYCLES;
        hold_req = 1'b1;
      end
      for (n = 0; n < PHASE_OPS; n++) begin
        // Midway through one phase the sender waits for every result.
        if (ph == 1 && n == PHASE_OPS / 2) drain_results();
        offer(draw_op(), 1'b0, '0);
        sender_gap();
      end
    end

    drain_results();
    if (mismatch_count == 0) begin
      $display("ordered_array_list_top_tb passed");
    end else begin
      $display("ordered_array_list_top_tb failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/oal_pkg.sv
rtl/core/oal_ram.sv
rtl/core/oal_dpath.sv
rtl/core/oal_ctrl.sv
rtl/core/ordered_array_list_top.sv
rtl/core/oal_checker.sv
test/ordered_array_list_top_tb.sv
